### hw/rtl/arp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_pkg
// command and status codes and stream field widths of the aging resource pool
// ----------------------------------------------------------------------------
package arp_pkg;

  // command codes (input tuser)
  localparam logic [1:0] CMD_ACQUIRE = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_BEGIN   = 2'd2;
  localparam logic [1:0] CMD_CLEAR   = 2'd3;

  // status codes (output tuser)
  localparam logic [1:0] ST_REUSED   = 2'd0;
  localparam logic [1:0] ST_APPENDED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_DONE     = 2'd3;

  // stream field widths
  localparam int unsigned KEY_FIELD_W   = 32;
  localparam int unsigned REL_FIELD_W   = 6;
  localparam int unsigned GRANT_FIELD_W = 6;
  localparam int unsigned REM_FIELD_W   = 7;
  localparam int unsigned LIMIT_W       = 8;
  localparam int unsigned IN_TDATA_W    = 40;
  localparam int unsigned OUT_TDATA_W   = 16;

  typedef logic [1:0] code_t;

endpackage

### hw/rtl/arp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_ram
// entry table storage: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module arp_ram #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6,
  parameter int unsigned DATA_W = 41
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/aging_resource_pool.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_resource_pool
// packed pool table with key reuse, append, release and age based retirement
// ----------------------------------------------------------------------------
// The pool keeps a packed table of entries (key, in-use mark, idle age) in
// one synchronous memory and handles one command at a time. Acquire walks the
// occupied entries one read per cycle looking for the lowest free entry with
// a matching key and appends when none matches and the table is not full.
// Begin frame walks every occupied entry once, ages it, drops the expired
// ones and compacts the survivors, marked free again, in place. Release is a
// read-modify-write of one entry (an out of range index is ignored) and
// clear resets the occupied count. The memory read port delivers one entry
// per cycle; a stalled result channel holds the pool in its done state.
// One result transfer comes back for every command transfer; a new command
// is accepted while the previous result still waits in the output register.
// The table memory needs no clearing after reset: only entries below the
// occupied count are ever used, and each of those was written by an append
// or by a compaction.
// ----------------------------------------------------------------------------
module aging_resource_pool #(
  parameter int unsigned POOL_ENTRIES = 64,
  parameter int unsigned KEY_BITS     = 32,
  parameter int unsigned AGE_BITS     = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // command channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [arp_pkg::IN_TDATA_W-1:0]      in_tdata,  // descriptor_key[31:0], release_index[37:32]
  input  logic [1:0]                          in_tuser,  // command[1:0]
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [arp_pkg::OUT_TDATA_W-1:0]     out_tdata, // granted_index[5:0], removed_count[12:6]
  output logic [1:0]                          out_tuser, // status[1:0]
  // retire limit register
  input  logic                                cfg_wr_en,
  input  logic [arp_pkg::LIMIT_W-1:0]         cfg_wr_data
);

  import arp_pkg::*;

  localparam int unsigned IDX_W = $clog2(POOL_ENTRIES);
  localparam int unsigned CNT_W = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned ENT_W = KEY_BITS + 1 + AGE_BITS;
  localparam int unsigned REL_CMP_W = (CNT_W > REL_FIELD_W) ? CNT_W : REL_FIELD_W;
  localparam int unsigned AGE_CMP_W = (AGE_BITS > LIMIT_W) ? AGE_BITS : LIMIT_W;
  localparam logic [CNT_W-1:0]    CNT_FULL = CNT_W'(POOL_ENTRIES);
  localparam logic [AGE_BITS-1:0] AGE_MAX  = {AGE_BITS{1'b1}};

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_REL_RD = 3'd2;
  localparam logic [2:0] S_REL_WR = 3'd3;
  localparam logic [2:0] S_SWEEP  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]          state_r, state_nxt;
  code_t               cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [REL_FIELD_W-1:0] rel_r, rel_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    issue_r, issue_nxt;     // next entry to read
  logic                pend_r, pend_nxt;       // read data valid this cycle
  logic [IDX_W-1:0]    pidx_r, pidx_nxt;       // entry behind the read data
  logic [CNT_W-1:0]    dst_r, dst_nxt;         // compaction write pointer
  logic [CNT_W-1:0]    gone_r, gone_nxt;       // entries retired so far
  logic [IDX_W-1:0]    res_idx_r, res_idx_nxt;
  code_t               res_status_r, res_status_nxt;
  logic [CNT_W-1:0]    res_removed_r, res_removed_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [GRANT_FIELD_W-1:0] out_idx_r, out_idx_nxt;
  code_t               out_status_r, out_status_nxt;
  logic [REM_FIELD_W-1:0]   out_removed_r, out_removed_nxt;
  logic [LIMIT_W-1:0]  limit_r;

  // memory port
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [ENT_W-1:0]    ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic [ENT_W-1:0]    ram_rdata;

  // input field unpacking, key zero extended or cut to the table key width
  logic [KEY_BITS+KEY_FIELD_W-1:0] key_wide;
  logic [KEY_BITS-1:0]             in_key;
  logic [REL_FIELD_W-1:0]          in_rel;

  assign key_wide = {{KEY_BITS{1'b0}}, in_tdata[KEY_FIELD_W-1:0]};
  assign in_key   = key_wide[KEY_BITS-1:0];
  assign in_rel   = in_tdata[KEY_FIELD_W +: REL_FIELD_W];

  // read data fields: {key, busy, age}
  logic [KEY_BITS-1:0] rd_key;
  logic                rd_busy;
  logic [AGE_BITS-1:0] rd_age;
  logic [AGE_BITS-1:0] age_inc;
  logic                scan_hit;
  logic                age_expired;
  logic                rel_in_range;
  logic                in_xfer;

  assign rd_key  = ram_rdata[ENT_W-1 -: KEY_BITS];
  assign rd_busy = ram_rdata[AGE_BITS];
  assign rd_age  = ram_rdata[AGE_BITS-1:0];

  // saturating age step and retire test
  assign age_inc     = (rd_age == AGE_MAX) ? rd_age : rd_age + AGE_BITS'(1);
  assign age_expired = AGE_CMP_W'(age_inc) > AGE_CMP_W'(limit_r);
  assign scan_hit    = pend_r && !rd_busy && (rd_key == key_r);
  assign rel_in_range = REL_CMP_W'(rel_r) < REL_CMP_W'(count_r);

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  arp_ram #(
    .DEPTH  (POOL_ENTRIES),
    .ADDR_W (IDX_W),
    .DATA_W (ENT_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    key_nxt         = key_r;
    rel_nxt         = rel_r;
    count_nxt       = count_r;
    issue_nxt       = issue_r;
    pend_nxt        = pend_r;
    pidx_nxt        = pidx_r;
    dst_nxt         = dst_r;
    gone_nxt        = gone_r;
    res_idx_nxt     = res_idx_r;
    res_status_nxt  = res_status_r;
    res_removed_nxt = res_removed_r;
    out_tvalid_nxt  = out_tvalid_r && !out_tready;
    out_idx_nxt     = out_idx_r;
    out_status_nxt  = out_status_r;
    out_removed_nxt = out_removed_r;
    ram_we          = 1'b0;
    ram_waddr       = pidx_r;
    ram_wdata       = {key_r, 1'b1, {AGE_BITS{1'b0}}};
    ram_raddr       = issue_r[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_nxt   = in_tuser;
          key_nxt   = in_key;
          rel_nxt   = in_rel;
          issue_nxt = '0;
          pend_nxt  = 1'b0;
          dst_nxt   = '0;
          gone_nxt  = '0;
          unique case (in_tuser)
            CMD_ACQUIRE: state_nxt = S_SCAN;
            CMD_RELEASE: state_nxt = S_REL_RD;
            CMD_BEGIN:   state_nxt = S_SWEEP;
            CMD_CLEAR: begin
              res_idx_nxt     = '0;
              res_status_nxt  = ST_DONE;
              res_removed_nxt = count_r;
              count_nxt       = '0;
              state_nxt       = S_DONE;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      // one read issued per cycle, compared in the cycle after
      S_SCAN: begin
        priority if (scan_hit) begin
          // lowest free match: mark in use, age back to zero
          ram_we          = 1'b1;
          ram_waddr       = pidx_r;
          ram_wdata       = {key_r, 1'b1, {AGE_BITS{1'b0}}};
          pend_nxt        = 1'b0;
          res_idx_nxt     = pidx_r;
          res_status_nxt  = ST_REUSED;
          res_removed_nxt = '0;
          state_nxt       = S_DONE;
        end else if (issue_r < count_r) begin
          ram_raddr = issue_r[IDX_W-1:0];
          pend_nxt  = 1'b1;
          pidx_nxt  = issue_r[IDX_W-1:0];
          issue_nxt = issue_r + CNT_W'(1);
        end else if (pend_r) begin
          // last compare missed, drain
          pend_nxt = 1'b0;
        end else begin
          res_removed_nxt = '0;
          state_nxt       = S_DONE;
          if (count_r < CNT_FULL) begin
            ram_we         = 1'b1;
            ram_waddr      = count_r[IDX_W-1:0];
            ram_wdata      = {key_r, 1'b1, {AGE_BITS{1'b0}}};
            count_nxt      = count_r + CNT_W'(1);
            res_idx_nxt    = count_r[IDX_W-1:0];
            res_status_nxt = ST_APPENDED;
          end else begin
            res_idx_nxt    = '0;
            res_status_nxt = ST_FULL;
          end
        end
      end

      S_REL_RD: begin
        ram_raddr       = IDX_W'(rel_r);
        res_idx_nxt     = '0;
        res_status_nxt  = ST_DONE;
        res_removed_nxt = '0;
        // out of range release is ignored
        state_nxt       = rel_in_range ? S_REL_WR : S_DONE;
      end

      S_REL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(rel_r);
        ram_wdata = {rd_key, 1'b0, rd_age};
        state_nxt = S_DONE;
      end

      // compaction writes stay at or below the entry being processed, so
      // they never land on an entry still to be read
      S_SWEEP: begin
        if (pend_r) begin
          if (age_expired) begin
            gone_nxt = gone_r + CNT_W'(1);
          end else begin
            ram_we    = 1'b1;
            ram_waddr = dst_r[IDX_W-1:0];
            ram_wdata = {rd_key, 1'b0, age_inc};
            dst_nxt   = dst_r + CNT_W'(1);
          end
        end
        if (issue_r < count_r) begin
          ram_raddr = issue_r[IDX_W-1:0];
          pend_nxt  = 1'b1;
          issue_nxt = issue_r + CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            count_nxt       = dst_r;
            res_idx_nxt     = '0;
            res_status_nxt  = ST_DONE;
            res_removed_nxt = gone_r;
            state_nxt       = S_DONE;
          end
        end
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt  = 1'b1;
          out_idx_nxt     = GRANT_FIELD_W'(res_idx_r);
          out_status_nxt  = res_status_r;
          out_removed_nxt = REM_FIELD_W'(res_removed_r);
          state_nxt       = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_r       <= pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // retire limit register, reset value two frames
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_W'(2);
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    key_r         <= key_nxt;
    rel_r         <= rel_nxt;
    issue_r       <= issue_nxt;
    pidx_r        <= pidx_nxt;
    dst_r         <= dst_nxt;
    gone_r        <= gone_nxt;
    res_idx_r     <= res_idx_nxt;
    res_status_r  <= res_status_nxt;
    res_removed_r <= res_removed_nxt;
    out_idx_r     <= out_idx_nxt;
    out_status_r  <= out_status_nxt;
    out_removed_r <= out_removed_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W - GRANT_FIELD_W - REM_FIELD_W){1'b0}},
                       out_removed_r, out_idx_r};
  assign out_tuser  = out_status_r;

endmodule
